// ===== src/sctb_pkg.sv =====
// Shared types and constants for the span clipper.
`default_nettype none
package sctb_pkg;

  localparam int unsigned MaxBoxesDefault = 64;
  localparam int unsigned CountW = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned BoxW = 64;

  localparam logic [CfgIdxW-1:0] CfgBoxCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSortedMode = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgYMax = 2'd2;

  localparam logic CmdLoadBox = 1'b0;
  localparam logic CmdClipSpan = 1'b1;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
  } box_t;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [15:0] y;
    logic [15:0]        length;
    logic [15:0]        offset;
    logic               last;
  } seg_t;

endpackage
`default_nettype wire

// ===== src/sctb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sctb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/sctb_seg.sv =====
// Clips one span against one rectangle and forms the segment fields.
`default_nettype none
module sctb_seg import sctb_pkg::*; (
  input  wire box_t               box_i,
  input  wire logic signed [15:0] x_i,
  input  wire logic signed [16:0] xe_i,
  input  wire logic signed [15:0] y_i,
  output seg_t                    seg_o
);

  logic signed [15:0] xs;
  logic signed [16:0] right_ext;
  logic signed [16:0] xend;
  logic signed [17:0] len;
  logic signed [16:0] off;

  always_comb begin
    xs        = (box_i.left > x_i) ? box_i.left : x_i;
    right_ext = 17'(box_i.right);
    xend      = (right_ext < xe_i) ? right_ext : xe_i;
    len       = 18'(xend) - 18'(xs);
    off       = 17'(xs) - 17'(x_i);
    seg_o.x      = 17'(xs);
    seg_o.y      = y_i;
    // A malformed rectangle can put the clipped end before the start.
    seg_o.length = len[17] ? 16'd0 : len[15:0];
    seg_o.offset = off[15:0];
    seg_o.last   = 1'b0;
  end

endmodule
`default_nettype wire

// ===== src/span_clip_to_box_list_top.sv =====
// Top level of the span clipper: sequencer, rectangle table and output stage.
//
// Usage: an input item either loads one clip rectangle into the table
// (command 0) or clips one span (command 1). Both channels use valid and
// stall; an item moves at a clock edge with valid high and stall low.
// A rectangle load is written as it is accepted. A span walks the table one
// rectangle at a time through a single table read port, with an address step
// and then a compare-and-clip step for each rectangle visited. After its
// accept a span runs these steps and a closing step, plus one more address
// step when the walk runs to the end of the table. A span that is skipped
// by the row range or a stopped batch ends at its accept and stays idle.
// Each overlapping rectangle gives one segment; the final one of
// a span carries last. One segment is held back so that last can be set.
// in_stall_o is high while a span is in work. When the receiver stalls, the
// output register holds its item and the walk pauses at the next segment
// that needs room. Reset clears the configuration, band start, stop flag and
// all valid flags; the rectangle table is not cleared and must be loaded
// before use. The user must write configuration while idle (not enforced).
`default_nettype none
module span_clip_to_box_list_top import sctb_pkg::*; #(
  parameter int unsigned MAX_BOXES = MaxBoxesDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                command_i,
  input  wire logic [5:0]          box_index_i,
  input  wire logic signed [15:0]  box_left_i,
  input  wire logic signed [15:0]  box_top_i,
  input  wire logic signed [15:0]  box_right_i,
  input  wire logic signed [15:0]  box_bottom_i,
  input  wire logic signed [15:0]  span_x_i,
  input  wire logic signed [15:0]  span_y_i,
  input  wire logic [14:0]         span_width_i,
  input  wire logic                batch_start_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [16:0]       seg_x_o,
  output logic signed [15:0]       seg_y_o,
  output logic [15:0]              seg_length_o,
  output logic [15:0]              src_offset_o,
  output logic                     last_o
);

  localparam int unsigned AddrW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_BOXES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_e;

  state_e             state_q;
  logic [CountW-1:0]  box_count_q;
  logic               sorted_q;
  logic signed [16:0] y_max_q;
  logic [CountW-1:0]  band_q;
  logic               stopped_q;
  logic [CountW-1:0]  idx_q;
  logic signed [15:0] x_q;
  logic signed [15:0] y_q;
  logic signed [16:0] xe_q;
  logic               pend_valid_q;
  seg_t               pend_q;
  logic               out_valid_q;
  seg_t               out_q;

  logic [CountW-1:0]  n_act;
  logic               in_acc;
  logic               ram_we;
  logic               ram_re;
  logic [BoxW-1:0]    ram_rdata;
  box_t               box_w;
  box_t               box_r;
  seg_t               seg_new;
  seg_t               pend_last;
  logic               out_free;
  logic               hit_top, miss_bot, left_past, right_before, full_right, overlap;
  logic signed [16:0] span_y_ext;
  logic signed [16:0] span_xe;
  logic               span_live;
  logic               span_stop;
  logic               span_walk;
  logic               push_eval;
  logic               push_flush;
  logic               out_push;

  assign n_act  = (box_count_q > MaxCount) ? MaxCount : box_count_q;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign ram_we = in_acc && (command_i == CmdLoadBox) &&
                  (CountW'(box_index_i) < MaxCount);
  assign ram_re = (state_q == ST_READ) && (idx_q < n_act);
  assign out_free = !out_valid_q || !out_stall_i;
  assign span_y_ext = 17'(span_y_i);
  assign span_xe = 17'(span_x_i) + 17'(span_width_i);

  // A batch start revives a stopped batch before the span is looked at.
  assign span_live = !stopped_q || batch_start_i;
  assign span_stop = sorted_q && span_live && (span_y_ext >= y_max_q);
  assign span_walk = (sorted_q ? span_live : !span_y_i[15]) && (span_y_ext < y_max_q);

  always_comb begin
    box_w.left   = box_left_i;
    box_w.top    = box_top_i;
    box_w.right  = box_right_i;
    box_w.bottom = box_bottom_i;
  end

  sctb_ram #(
    .Width (BoxW),
    .Depth (MAX_BOXES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (box_index_i[AddrW-1:0]),
    .wdata_i (box_w),
    .re_i    (ram_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign box_r = box_t'(ram_rdata);

  sctb_seg u_seg (
    .box_i (box_r),
    .x_i   (x_q),
    .xe_i  (xe_q),
    .y_i   (y_q),
    .seg_o (seg_new)
  );

  always_comb begin
    hit_top      = box_r.top > y_q;
    miss_bot     = box_r.bottom <= y_q;
    left_past    = 17'(box_r.left) > xe_q;
    right_before = box_r.right <= x_q;
    full_right   = xe_q <= 17'(box_r.right);
    overlap      = !left_past && !right_before;
  end

  always_comb begin
    pend_last      = pend_q;
    pend_last.last = 1'b1;
  end

  // The held segment moves out when a new one replaces it or the span closes.
  assign push_eval  = (state_q == ST_EVAL) && !hit_top && !miss_bot &&
                      !(sorted_q && left_past) && overlap && pend_valid_q && out_free;
  assign push_flush = (state_q == ST_FLUSH) && pend_valid_q && out_free;
  assign out_push   = push_eval || push_flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      box_count_q  <= '0;
      sorted_q     <= 1'b0;
      y_max_q      <= '0;
      band_q       <= '0;
      stopped_q    <= 1'b0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgBoxCount:   box_count_q <= cfg_data_i[CountW-1:0];
          CfgSortedMode: sorted_q    <= cfg_data_i[0];
          CfgYMax:       y_max_q     <= cfg_data_i;
          default:       ;
        endcase
      end

      if (out_push) begin
        out_q       <= push_flush ? pend_last : pend_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (command_i == CmdClipSpan)) begin
            x_q  <= span_x_i;
            y_q  <= span_y_i;
            xe_q <= span_xe;
            if (batch_start_i) begin
              band_q <= '0;
            end
            if (span_stop) begin
              stopped_q <= 1'b1;
            end else if (batch_start_i) begin
              stopped_q <= 1'b0;
            end
            if (span_walk) begin
              idx_q   <= (sorted_q && !batch_start_i) ? band_q : '0;
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_q <= (idx_q < n_act) ? ST_EVAL : ST_FLUSH;
        end
        ST_EVAL: begin
          priority if (hit_top) begin
            state_q <= ST_FLUSH;
          end else if (miss_bot) begin
            idx_q <= idx_q + 1'b1;
            if (sorted_q) begin
              band_q <= idx_q + 1'b1;
            end
            state_q <= ST_READ;
          end else if (sorted_q && left_past) begin
            state_q <= ST_FLUSH;
          end else if (overlap) begin
            if (!pend_valid_q || out_free) begin
              pend_q       <= seg_new;
              pend_valid_q <= 1'b1;
              if (sorted_q && full_right) begin
                state_q <= ST_FLUSH;
              end else begin
                idx_q   <= idx_q + 1'b1;
                state_q <= ST_READ;
              end
            end
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_READ;
          end
        end
        ST_FLUSH: begin
          if (!pend_valid_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign seg_x_o      = out_q.x;
  assign seg_y_o      = out_q.y;
  assign seg_length_o = out_q.length;
  assign src_offset_o = out_q.offset;
  assign last_o       = out_q.last;

  // A held segment never survives past the end of its span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_valid_q)
    else $error("held segment left behind at end of span");

  // The walk only evaluates rectangles inside the active count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVAL |-> idx_q < n_act)
    else $error("table walk beyond the active rectangle count");

  // In sorted mode the band start never runs ahead of the walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && sorted_q) |-> band_q <= idx_q)
    else $error("band start ahead of walk index");

  // A segment is only pushed out while the output register has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(out_q))
    else $error("output item overwritten while stalled");

endmodule
`default_nettype wire
